// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/mf3cb_pkg.sv =====
// Package of constants, types and the masked median function of the median filter.
package mf3cb_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int CHANNELS    = 3;
	localparam int SAMPLE_BITS = 8;

	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int WCL_BITS    = COL_BITS + 1;
	localparam int WREG_BITS   = 11;
	localparam int HREG_BITS   = 16;
	localparam int ROW_BITS    = HREG_BITS + 1;
	localparam int PIX_BITS    = CHANNELS * SAMPLE_BITS;
	localparam int TDATA_BITS  = ((PIX_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;

	localparam logic [WREG_BITS-1:0] WIDTH_RESET  = 11'd512;
	localparam logic [HREG_BITS-1:0] HEIGHT_RESET = 16'd512;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [PIX_BITS-1:0]    pixel_t;
	typedef pixel_t [8:0]           window_t;

	// Element of rank n/2 among the samples whose mask bit is set.
	// Ties are broken by position so exactly one sample matches.
	function automatic sample_t mf3_median(input sample_t [8:0] v, input logic [8:0] mask);
		logic [3:0] n;
		logic [3:0] cnt;
		sample_t    res;
		n   = '0;
		res = '0;
		for (int i = 0; i < 9; i++) begin
			n = n + 4'(mask[i]);
		end
		for (int i = 0; i < 9; i++) begin
			cnt = '0;
			for (int j = 0; j < 9; j++) begin
				if (j != i && mask[j] && (v[j] < v[i] || (v[j] == v[i] && j < i))) begin
					cnt = cnt + 4'd1;
				end
			end
			if (mask[i] && cnt == (n >> 1)) begin
				res = res | v[i];
			end
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/median_filter_3x3_clipped_border_unit.sv =====
// Top level: 3x3 per-channel median filter over a raster pixel stream, border clipped.
// An accepted request is registered in stage one and its result in the result register;
// a full result register not taken stalls the input while stage one holds a result.
// Throughput: one request per cycle unless so stalled; the line memory is read at accept
// and written as the request leaves stage one. A result trails its pixel by one row
// plus one pixel. Reset clears counters, window, pipeline and output, sets sizes to 512.
module median_filter_3x3_clipped_border_unit import mf3cb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [TDATA_BITS-1:0]    s_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2
	input  logic                     s_tuser,   // is_flush
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [TDATA_BITS-1:0]    m_tdata,   // out_ch0, out_ch1, out_ch2
	output logic                     m_tlast,   // frame_last
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	// Size registers, as written.
	logic [WREG_BITS-1:0] width_q;
	logic [HREG_BITS-1:0] height_q;

	// Position of the next request.
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;

	// Line memory: upper row in the high half, middle row in the low half.
	logic [2*PIX_BITS-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_BITS-1:0] rd_q;
	logic                  fwd_q;
	logic [2*PIX_BITS-1:0] fwd_data_q;

	// Stage one: the request that has read its column.
	logic                valid_s1;
	logic                have_s1;
	logic                last_s1;
	logic                pre_s1;
	logic [8:0]          mask_s1;
	logic [COL_BITS-1:0] col_s1;
	pixel_t              pix_s1;

	window_t window_q;

	// Result register.
	logic                  out_valid_q;
	logic                  out_last_q;
	logic [PIX_BITS-1:0]   out_data_q;

	logic [WCL_BITS-1:0] wcl;
	logic [ROW_BITS-1:0] hx;
	logic [COL_BITS-1:0] c_eff;
	logic                accept;
	logic                ignored;
	logic                load_s1;
	logic                adv_s1;
	logic                have_a;
	logic                have_b;
	logic                last_now;
	logic [2:0]          rv;
	logic [2:0]          cv;
	logic [8:0]          mask_now;
	logic [WCL_BITS-1:0] col_inc;
	logic [2*PIX_BITS-1:0] col_data;
	logic [2*PIX_BITS-1:0] wr_data;
	window_t             window_next;
	window_t             window_src;
	logic [PIX_BITS-1:0] median;

	// Width 0 acts as 1 and widths above the line memory depth act as its depth;
	// height 0 acts as 1.
	always_comb begin
		if (width_q == '0) begin
			wcl = WCL_BITS'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			wcl = WCL_BITS'(MAX_WIDTH);
		end else begin
			wcl = WCL_BITS'(width_q);
		end
		hx = (height_q == '0) ? ROW_BITS'(1) : {1'b0, height_q};
	end

	// A column left over from a wider frame restarts at zero.
	assign c_eff = ({1'b0, col_q} >= wcl) ? '0 : col_q;

	// Flush requests while pixels are still due are taken and dropped.
	assign accept  = s_tvalid && s_tready;
	assign ignored = (row_q < hx) && s_tuser;
	assign load_s1 = accept && !ignored;

	// Interior columns give the result one up and one left; column zero gives the
	// last pixel of the row before the previous one from the window as it stood.
	// There the oldest window column lies two columns left of the center and is
	// never a neighbor.
	always_comb begin
		have_a   = (c_eff != '0) && (row_q != '0);
		have_b   = (c_eff == '0) && (row_q >= ROW_BITS'(2));
		last_now = have_b && (row_q == hx + ROW_BITS'(1));
		if (have_b) begin
			rv[0] = (row_q >= ROW_BITS'(3)) && (row_q - ROW_BITS'(3) < hx);
			rv[1] = (row_q - ROW_BITS'(2)) < hx;
			rv[2] = (row_q - ROW_BITS'(1)) < hx;
			cv[0] = 1'b0;
			cv[1] = wcl >= WCL_BITS'(2);
			cv[2] = 1'b1;
		end else begin
			rv[0] = (row_q >= ROW_BITS'(2)) && (row_q - ROW_BITS'(2) < hx);
			rv[1] = (row_q - ROW_BITS'(1)) < hx;
			rv[2] = row_q < hx;
			cv[0] = c_eff >= COL_BITS'(2);
			cv[1] = 1'b1;
			cv[2] = 1'b1;
		end
		for (int ri = 0; ri < 3; ri++) begin
			for (int ci = 0; ci < 3; ci++) begin
				mask_now[ri*3+ci] = rv[ri] & cv[ci];
			end
		end
		col_inc = {1'b0, c_eff} + WCL_BITS'(1);
	end

	// The stage moves on when it has no result or the result register is free.
	assign adv_s1   = valid_s1 && (!have_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_valid) begin
			// Any write of a known register restarts the frame.
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[WREG_BITS-1:0];
				col_q   <= '0;
				row_q   <= '0;
			end else if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[HREG_BITS-1:0];
				col_q    <= '0;
				row_q    <= '0;
			end
		end else if (load_s1) begin
			if (last_now) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= wcl) begin
				col_q <= '0;
				row_q <= row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	// The column vector: upper and middle rows from memory, or from the write of the
	// request just ahead when it went to the same column.
	assign col_data = fwd_q ? fwd_data_q : rd_q;
	assign wr_data  = {col_data[PIX_BITS-1:0], pix_s1};

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q       <= line_mem[c_eff];
			fwd_q      <= adv_s1 && (col_s1 == c_eff);
			fwd_data_q <= wr_data;
		end
		if (adv_s1) begin
			line_mem[col_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			have_s1 <= have_a || have_b;
			last_s1 <= last_now;
			pre_s1  <= have_b;
			mask_s1 <= mask_now;
			col_s1  <= c_eff;
			pix_s1  <= (row_q < hx) ? s_tdata[PIX_BITS-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Window shift: each row moves one column older and takes the new column vector.
	always_comb begin
		for (int ri = 0; ri < 3; ri++) begin
			window_next[ri*3+0] = window_q[ri*3+1];
			window_next[ri*3+1] = window_q[ri*3+2];
		end
		window_next[2] = col_data[2*PIX_BITS-1:PIX_BITS];
		window_next[5] = col_data[PIX_BITS-1:0];
		window_next[8] = pix_s1;
		window_src = pre_s1 ? window_q : window_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (adv_s1) begin
			window_q <= window_next;
		end
	end

	always_comb begin
		sample_t [8:0] v;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int k = 0; k < 9; k++) begin
				v[k] = window_src[k][ch*SAMPLE_BITS +: SAMPLE_BITS];
			end
			median[ch*SAMPLE_BITS +: SAMPLE_BITS] = mf3_median(v, mask_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && have_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && have_s1) begin
			out_data_q <= median;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = TDATA_BITS'(out_data_q);

endmodule

// ===== hw/rtl/mf3cb_checker.sv =====
// Port-level checker of the median filter and its bind to the top level.
`include "assert_macros.svh"

module mf3cb_checker import mf3cb_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [TDATA_BITS-1:0]    m_tdata,
	input logic                     m_tlast
);

	logic in_acc;
	logic out_stall;
	assign in_acc    = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;

	// A stalled result stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid)
	// With the result register empty the input side is never stalled.
	`ASSERT_IMPLY(a_ready_free, clk, arst_n, !m_tvalid, s_tready)
	// A new result follows an accepted request that passed stage one into the result register.
	`ASSERT_IMPLY(a_rise_src, clk, arst_n, $rose(m_tvalid), $past(in_acc, 2))
	// A result shown while stalled keeps its data and its frame mark.
	`ASSERT_NEXT(a_last_hold, clk, arst_n, out_stall, $stable(m_tlast) && $stable(m_tdata))

endmodule

bind median_filter_3x3_clipped_border_unit mf3cb_checker u_mf3cb_checker (.*);
